FILE: sv/owb_pkg.sv
// Package for the 1-Wire bus master: item types, command and phase codes,
// and the nominal slot length table. No dependencies.
package owb_pkg;

  // Widths of the slot timing datapath.
  localparam int unsigned BASE_W  = 10;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned CNT_W   = BASE_W + SCALE_W;
  localparam int unsigned PHASE_W = 4;

  // Command codes carried by the kind field.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_RESET  = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_SEARCH = 3'd4;

  // Phase codes of the bus sequencer.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RLOW  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RREL  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RREC  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SLOW  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SWAIT = 4'd5;
  localparam logic [PHASE_W-1:0] PH_STAIL = 4'd6;
  localparam logic [PHASE_W-1:0] PH_ZLOW  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_ZREL  = 4'd8;

  // Search triplet status when no device answered.
  localparam logic [2:0] TRIP_NONE = 3'd3;

  // Input item.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       direction;
    logic       line_level;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       reset_sample;
    logic [2:0] triplet_status;
    logic       rejected;
  } res_t;

  // Controls from the sequencer to the slot timer.
  typedef struct packed {
    logic tick;
    logic start;
  } timer_ctl_t;

  // Nominal length in microseconds of each fixed phase; the recovery
  // phase is handled by the caller.
  function automatic logic [BASE_W-1:0] phase_base(input logic [PHASE_W-1:0] ph);
    logic [BASE_W-1:0] base;
    unique case (ph)
      PH_RLOW:  base = 10'd480;
      PH_RREL:  base = 10'd70;
      PH_SLOW:  base = 10'd6;
      PH_SWAIT: base = 10'd9;
      PH_STAIL: base = 10'd55;
      PH_ZLOW:  base = 10'd60;
      PH_ZREL:  base = 10'd10;
      default:  base = '0;
    endcase
    return base;
  endfunction

endpackage

FILE: sv/owb_intf.sv
// Handshake channels of the 1-Wire bus master: command items, result items
// and configuration writes. Depends on owb_pkg.
interface owb_cmd_if;
  logic          valid;
  logic          ready;
  owb_pkg::cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface owb_res_if;
  logic          valid;
  logic          ready;
  owb_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface owb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/one_wire_bus_master_slots.sv
// 1-Wire bus master with tick-timed slots. An accepted item waits in the input
// register, passes through the sequencer and slot timer and is offered from the
// result register. Throughput: one item per cycle. A waiting result holds up the
// stage before it, so the input stalls once both the input register and the result
// register are full.
// Reset clears the sequencer to idle, the delay scale to 1 and both stages to empty.
module one_wire_bus_master_slots #(
  parameter int unsigned RECOVERY_US = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  owb_cmd_if.sink     in_i,
  owb_res_if.source   res_o,
  owb_cfg_if.sink     cfg_i
);

  logic                        s1_valid_q;
  owb_pkg::cmd_t               s1_cmd_q;
  logic                        out_valid_q;
  owb_pkg::res_t               out_res_q;
  owb_pkg::res_t               core_res;
  logic                        core_en;
  logic [owb_pkg::SCALE_W-1:0] scale_q;

  // Stage handshake: the core runs when the result register can take its item.
  assign core_en     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready  = !s1_valid_q || core_en;
  assign cfg_i.ready = 1'b1;

  // Delay scale register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 8'd1;
    end else if (cfg_i.valid) begin
      scale_q <= cfg_i.data;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q <= in_i.payload;
    end
  end

  owb_ctrl #(
    .RECOVERY_US(RECOVERY_US)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (core_en),
    .cmd_i  (s1_cmd_q),
    .scale_i(scale_q),
    .res_o  (core_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_en) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_res_q;

  // A dropped command leaves the running command busy.
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.rejected |-> out_res_q.busy_res)
    else $error("rejected result without a busy command");

  // A completing item leaves the bus idle and released.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.done_res |-> !out_res_q.busy_res && !out_res_q.drive_low)
    else $error("done result with the sequencer still busy");

  // The bus is only pulled low during a command.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.drive_low |-> out_res_q.busy_res)
    else $error("bus driven low while idle");

  // A held item in the input register is neither lost nor changed.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !core_en |=> s1_valid_q && $stable(s1_cmd_q))
    else $error("input register lost a waiting item");

endmodule

FILE: sv/owb_slot_timer.sv
// Slot timer of the 1-Wire bus master: tick counter and phase length compare.
// Depends on owb_pkg.
module owb_slot_timer #(
  parameter int unsigned RECOVERY_US = 1000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  owb_pkg::timer_ctl_t              ctl_i,
  input  logic [owb_pkg::PHASE_W-1:0]      phase_i,
  input  logic [owb_pkg::SCALE_W-1:0]      scale_i,
  output logic                             expired_o
);

  logic [owb_pkg::BASE_W-1:0] base;
  logic [owb_pkg::CNT_W-1:0]  len;
  logic [owb_pkg::CNT_W-1:0]  cnt_inc;
  logic [owb_pkg::CNT_W-1:0]  cnt_d;
  logic [owb_pkg::CNT_W-1:0]  cnt_q;

  // Phase length in ticks: nominal microseconds times the scale.
  always_comb begin
    if (phase_i == owb_pkg::PH_RREC) begin
      base = owb_pkg::BASE_W'(RECOVERY_US);
    end else begin
      base = owb_pkg::phase_base(phase_i);
    end
    len = owb_pkg::CNT_W'(base) * owb_pkg::CNT_W'(scale_i);
  end

  // A phase ends on the tick that brings the count up to its length.
  assign cnt_inc   = cnt_q + 1'b1;
  assign expired_o = (cnt_inc >= len);

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.start) begin
      cnt_d = '0;
    end else if (ctl_i.tick) begin
      cnt_d = expired_o ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/owb_ctrl.sv
// Bus sequencer of the 1-Wire bus master: phase state, shift registers and
// search logic; produces one result per item. Depends on owb_pkg, owb_slot_timer.
module owb_ctrl #(
  parameter int unsigned RECOVERY_US = 1000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  owb_pkg::cmd_t               cmd_i,
  input  logic [owb_pkg::SCALE_W-1:0] scale_i,
  output owb_pkg::res_t               res_o
);

  logic [owb_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [2:0]                  bit_idx_q, bit_idx_d;
  logic [7:0]                  tx_q, tx_d;
  logic [7:0]                  rx_q, rx_d;
  logic [2:0]                  act_cmd_q, act_cmd_d;
  logic [2:0]                  search_q, search_d;
  logic                        pres_q, pres_d;

  owb_pkg::timer_ctl_t tctl;
  logic                expired;
  logic                fin;
  logic                done;
  logic                rej;
  logic [2:0]          bit_next;
  logic                slot_bit;
  logic                id_bit;
  logic                cmpl_bit;
  logic                dir_bit;

  owb_slot_timer #(
    .RECOVERY_US(RECOVERY_US)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (tctl),
    .phase_i  (phase_q),
    .scale_i  (scale_i),
    .expired_o(expired)
  );

  // Next-state logic for one item.
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    act_cmd_d = act_cmd_q;
    search_d  = search_q;
    pres_d    = pres_q;
    tctl      = '0;
    fin       = 1'b0;
    rej       = 1'b0;
    bit_next  = bit_idx_q + 3'd1;
    slot_bit  = (act_cmd_q == owb_pkg::KIND_READ) ? 1'b1 : tx_q[bit_next];
    id_bit    = search_q[0];
    cmpl_bit  = search_q[1];
    dir_bit   = (!id_bit && !cmpl_bit) ? tx_q[0] : id_bit;

    if (en_i) begin
      unique case (cmd_i.kind) inside
        owb_pkg::KIND_TICK: begin
          if (phase_q != owb_pkg::PH_IDLE) begin
            tctl.tick = 1'b1;
            if (expired) begin
              unique case (phase_q) inside
                owb_pkg::PH_RLOW: phase_d = owb_pkg::PH_RREL;
                owb_pkg::PH_RREL: begin
                  pres_d  = cmd_i.line_level;
                  phase_d = owb_pkg::PH_RREC;
                end
                owb_pkg::PH_SLOW: phase_d = owb_pkg::PH_SWAIT;
                owb_pkg::PH_SWAIT: begin
                  // Sample the bus at the end of the read wait.
                  if (act_cmd_q == owb_pkg::KIND_SEARCH) begin
                    if (bit_idx_q == 3'd0) begin
                      search_d[0] = search_q[0] | cmd_i.line_level;
                    end else if (bit_idx_q == 3'd1) begin
                      search_d[1] = search_q[1] | cmd_i.line_level;
                    end
                  end else begin
                    rx_d[bit_idx_q] = rx_q[bit_idx_q] | cmd_i.line_level;
                  end
                  phase_d = owb_pkg::PH_STAIL;
                end
                owb_pkg::PH_ZLOW: phase_d = owb_pkg::PH_ZREL;
                owb_pkg::PH_STAIL, owb_pkg::PH_ZREL: begin
                  // End of a slot: start the next one or finish the command.
                  if (act_cmd_q == owb_pkg::KIND_WRITE || act_cmd_q == owb_pkg::KIND_READ) begin
                    if (bit_idx_q == 3'd7) begin
                      fin = 1'b1;
                    end else begin
                      bit_idx_d = bit_next;
                      phase_d   = slot_bit ? owb_pkg::PH_SLOW : owb_pkg::PH_ZLOW;
                    end
                  end else if (act_cmd_q == owb_pkg::KIND_SEARCH) begin
                    if (bit_idx_q == 3'd0) begin
                      bit_idx_d = 3'd1;
                      phase_d   = owb_pkg::PH_SLOW;
                    end else if (bit_idx_q == 3'd1) begin
                      if (id_bit && cmpl_bit) begin
                        search_d = owb_pkg::TRIP_NONE;
                        fin      = 1'b1;
                      end else begin
                        search_d  = {dir_bit, cmpl_bit, id_bit};
                        bit_idx_d = 3'd2;
                        phase_d   = dir_bit ? owb_pkg::PH_SLOW : owb_pkg::PH_ZLOW;
                      end
                    end else begin
                      fin = 1'b1;
                    end
                  end else begin
                    fin = 1'b1;
                  end
                end
                default: fin = 1'b1;
              endcase
            end
          end
        end
        owb_pkg::KIND_RESET, owb_pkg::KIND_WRITE, owb_pkg::KIND_READ,
        owb_pkg::KIND_SEARCH: begin
          if (phase_q != owb_pkg::PH_IDLE) begin
            rej = 1'b1;
          end else begin
            // Start a command; its first phase shows in this item's result.
            tctl.start = 1'b1;
            act_cmd_d  = cmd_i.kind;
            bit_idx_d  = '0;
            unique case (cmd_i.kind)
              owb_pkg::KIND_RESET: phase_d = owb_pkg::PH_RLOW;
              owb_pkg::KIND_WRITE: begin
                tx_d    = cmd_i.data_byte;
                rx_d    = '0;
                phase_d = cmd_i.data_byte[0] ? owb_pkg::PH_SLOW : owb_pkg::PH_ZLOW;
              end
              owb_pkg::KIND_READ: begin
                rx_d    = '0;
                phase_d = owb_pkg::PH_SLOW;
              end
              default: begin
                tx_d     = {7'd0, cmd_i.direction};
                search_d = '0;
                phase_d  = owb_pkg::PH_SLOW;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    if (fin) begin
      phase_d = owb_pkg::PH_IDLE;
    end
  end

  assign done = fin;

  // Result fields follow the state after this item.
  always_comb begin
    res_o.drive_low      = (phase_d == owb_pkg::PH_RLOW) || (phase_d == owb_pkg::PH_SLOW) ||
                           (phase_d == owb_pkg::PH_ZLOW);
    res_o.busy_res       = (phase_d != owb_pkg::PH_IDLE);
    res_o.done_res       = done;
    res_o.rx_byte        = rx_d;
    res_o.reset_sample   = pres_d;
    res_o.triplet_status = search_d;
    res_o.rejected       = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= owb_pkg::PH_IDLE;
      bit_idx_q <= '0;
      tx_q      <= '0;
      rx_q      <= '0;
      act_cmd_q <= '0;
      search_q  <= '0;
      pres_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      tx_q      <= tx_d;
      rx_q      <= rx_d;
      act_cmd_q <= act_cmd_d;
      search_q  <= search_d;
      pres_q    <= pres_d;
    end
  end

endmodule
